@@ hdl/vgmp_pkg.sv @@
// Shared types and constants of the VGM command stream player.
package vgmp_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_WRITE   = 3'd1,
    EV_WAIT    = 3'd2,
    EV_END     = 3'd3,
    EV_UNKNOWN = 3'd4
  } event_t;

  typedef enum logic [4:0] {
    PH_CMD     = 5'b00001,
    PH_WRITE   = 5'b00010,
    PH_DISCARD = 5'b00100,
    PH_WAIT_LO = 5'b01000,
    PH_WAIT_HI = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    MODE_PROC = 3'b001,
    MODE_WAIT = 3'b010,
    MODE_DONE = 3'b100
  } mode_t;

  localparam logic [7:0]  CMD_CHIP_WRITE   = 8'h50;
  localparam logic [7:0]  CMD_SKIP_A       = 8'h30;
  localparam logic [7:0]  CMD_SKIP_B       = 8'h4F;
  localparam logic [7:0]  CMD_WAIT_N       = 8'h61;
  localparam logic [7:0]  CMD_WAIT_NTSC    = 8'h62;
  localparam logic [7:0]  CMD_WAIT_PAL     = 8'h63;
  localparam logic [7:0]  CMD_END          = 8'h66;
  localparam logic [7:0]  CMD_SHORT_FIRST  = 8'h70;
  localparam logic [7:0]  CMD_SHORT_LAST   = 8'h7F;
  localparam logic [3:0]  SHORT_WAIT_MASK  = 4'hF;
  localparam logic [15:0] SAMPLES_NTSC     = 16'd735;
  localparam logic [15:0] SAMPLES_PAL      = 16'd882;

endpackage

@@ hdl/vgmp_if.sv @@
// Request and result channel interfaces of the VGM command stream player.
interface vgmp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  stream_byte;
  logic [15:0] tick_increment;

  modport source (output valid, kind, stream_byte, tick_increment, input ready);
  modport sink   (input valid, kind, stream_byte, tick_increment, output ready);
endinterface

interface vgmp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  event_byte;
  logic [15:0] wait_samples;
  logic [31:0] current_position;
  logic [31:0] target_position;
  logic        want_more;
  logic        busy_res;

  modport source (output valid, event_res, event_byte, wait_samples, current_position,
                  target_position, want_more, busy_res, input ready);
  modport sink   (input valid, event_res, event_byte, wait_samples, current_position,
                  target_position, want_more, busy_res, output ready);
endinterface

@@ hdl/vgm_command_stream_player_top.sv @@
// Top level of the VGM command stream player.
// Takes one request per cycle (stream byte, sample tick or start marker) and returns
// exactly one result per request: a request register feeds the command decoder
// and the position adder, whose output lands in the result register. The parser
// state and both 32-bit positions update in that same cycle, so requests follow
// back to back; the only thing that slows the rate is res.ready.
module vgm_command_stream_player_top (
  input  logic       clk,
  input  logic       rst,
  vgmp_in_if.sink    cmd,
  vgmp_out_if.source res
);
  import vgmp_pkg::*;

  logic        s1_valid;
  kind_t       s1_kind;
  logic [7:0]  s1_byte;
  logic [15:0] s1_tick;

  phase_t      phase, phase_next;
  mode_t       mode, mode_next;
  logic [7:0]  wait_low, wait_low_next;
  logic [31:0] current, current_next;
  logic [31:0] target, target_next;

  logic        out_valid;
  event_t      out_event;
  logic [7:0]  out_byte;
  logic [15:0] out_wait;
  logic [31:0] out_current;
  logic [31:0] out_target;
  logic        out_more;
  logic        out_busy;

  event_t      ev;
  logic [7:0]  ev_byte;
  logic        do_wait;
  logic [15:0] wait_add;
  logic [15:0] ws;
  logic        more;
  logic        advance;

  assign advance   = !out_valid || res.ready;
  assign cmd.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      s1_kind <= kind_t'(cmd.kind);
      s1_byte <= cmd.stream_byte;
      s1_tick <= cmd.tick_increment;
    end
  end

  always_comb begin
    phase_next    = phase;
    mode_next     = mode;
    wait_low_next = wait_low;
    current_next  = current;
    target_next   = target;
    ev            = EV_NONE;
    ev_byte       = 8'd0;
    do_wait       = 1'b0;
    wait_add      = 16'd0;
    ws            = 16'd0;
    case (s1_kind)
      KIND_BYTE: begin
        if (mode != MODE_DONE) begin
          case (phase)
            PH_WRITE: begin
              phase_next = PH_CMD;
              ev         = EV_WRITE;
              ev_byte    = s1_byte;
            end
            PH_DISCARD: begin
              phase_next = PH_CMD;
            end
            PH_WAIT_LO: begin
              wait_low_next = s1_byte;
              phase_next    = PH_WAIT_HI;
            end
            PH_WAIT_HI: begin
              phase_next = PH_CMD;
              do_wait    = 1'b1;
              wait_add   = {s1_byte, wait_low};
            end
            default: begin
              phase_next = PH_CMD;
              mode_next  = MODE_PROC;
              if (s1_byte inside {[CMD_SHORT_FIRST:CMD_SHORT_LAST]}) begin
                do_wait  = 1'b1;
                wait_add = 16'({1'b0, s1_byte[3:0] & SHORT_WAIT_MASK} + 5'd1);
              end else begin
                case (s1_byte)
                  CMD_CHIP_WRITE: phase_next = PH_WRITE;
                  CMD_SKIP_A, CMD_SKIP_B: phase_next = PH_DISCARD;
                  CMD_WAIT_N: phase_next = PH_WAIT_LO;
                  CMD_WAIT_NTSC: begin
                    do_wait  = 1'b1;
                    wait_add = SAMPLES_NTSC;
                  end
                  CMD_WAIT_PAL: begin
                    do_wait  = 1'b1;
                    wait_add = SAMPLES_PAL;
                  end
                  CMD_END: begin
                    mode_next = MODE_DONE;
                    ev        = EV_END;
                  end
                  default: begin
                    ev      = EV_UNKNOWN;
                    ev_byte = s1_byte;
                  end
                endcase
              end
            end
          endcase
        end
      end
      KIND_TICK: begin
        target_next = target + {16'd0, s1_tick};
      end
      KIND_START: begin
        phase_next    = PH_CMD;
        mode_next     = MODE_PROC;
        wait_low_next = 8'd0;
        current_next  = 32'd0;
        target_next   = 32'd0;
      end
      default: ;
    endcase
    if (do_wait) begin
      current_next = current + {16'd0, wait_add};
      mode_next    = MODE_WAIT;
      ev           = EV_WAIT;
      ws           = wait_add;
    end
    more = (mode_next == MODE_PROC) ||
           ((mode_next == MODE_WAIT) && (current_next < target_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CMD;
      mode      <= MODE_PROC;
      wait_low  <= 8'd0;
      current   <= 32'd0;
      target    <= 32'd0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        phase    <= phase_next;
        mode     <= mode_next;
        wait_low <= wait_low_next;
        current  <= current_next;
        target   <= target_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_event   <= ev;
      out_byte    <= ev_byte;
      out_wait    <= ws;
      out_current <= current_next;
      out_target  <= target_next;
      out_more    <= more;
      out_busy    <= (mode_next != MODE_DONE);
    end
  end

  assign res.valid            = out_valid;
  assign res.event_res        = out_event;
  assign res.event_byte       = out_byte;
  assign res.wait_samples     = out_wait;
  assign res.current_position = out_current;
  assign res.target_position  = out_target;
  assign res.want_more        = out_more;
  assign res.busy_res         = out_busy;

  a_end_clears_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_event == EV_END) |-> !out_busy)
    else $error("end of data reported while still busy");

  a_done_wants_nothing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_busy) |-> !out_more)
    else $error("more data requested after end of data");

  a_byte_only_on_data_events: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_event != EV_WRITE && out_event != EV_UNKNOWN) |-> out_byte == 8'd0)
    else $error("event byte set on an event that carries none");

  a_done_at_command_phase: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_DONE) |-> (phase == PH_CMD))
    else $error("parser left inside a command after end of data");

endmodule
